>>> rtl/assert_macros.svh
// Assertion helpers shared by the bit packer RTL.
// Every macro expects clk and the active-low rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset
`define JBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define JBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/jbp_pkg.sv
// Package for the entropy bit packer: payload structs and fixed constants.
// No dependencies; used by every RTL module of the block.
package jbp_pkg;

  localparam int CODE_VAL_W = 16;
  localparam int CODE_LEN_W = 5;
  localparam int BYTE_BITS  = 8;
  localparam int PEND_W     = 7;
  localparam int CNT_W      = 3;

  localparam logic [BYTE_BITS-1:0] STUFF_MARK = 8'hFF;
  localparam logic [BYTE_BITS-1:0] STUFF_FILL = 8'h00;

  // Input request: one variable-length code
  typedef struct packed {
    logic [CODE_VAL_W-1:0] code_value;
    logic [CODE_LEN_W-1:0] code_length;
  } jbp_in_t;

  // Output request: one stream byte
  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last_of_run;
  } jbp_out_t;

endpackage

>>> rtl/jbp_front.sv
// Front end: accepts codes, merges them with the pending bits and splits
// complete bytes off into a descriptor. Depends on jbp_pkg.
module jbp_front #(
  parameter int MAX_CODE_BITS = 16,
  parameter int MAX_BYTES     = (MAX_CODE_BITS + 7) / 8,
  parameter int NBW           = $clog2(MAX_BYTES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jbp_pkg::jbp_in_t               in_data,
  input  logic                           q_full,
  output logic                           push,
  output logic [MAX_BYTES-1:0][7:0]      push_bytes,
  output logic [NBW-1:0]                 push_nb
);
  import jbp_pkg::*;

  localparam int WBITS = PEND_W + MAX_CODE_BITS;
  localparam int TW    = $clog2(WBITS + 1);
  localparam int CW    = (TW > CODE_LEN_W) ? TW : CODE_LEN_W;
  localparam int BSH   = $clog2(BYTE_BITS);

  logic [PEND_W-1:0]           pend_bits_r, pend_bits_nxt;
  logic [CNT_W-1:0]            pend_cnt_r, pend_cnt_nxt;
  logic                        accept;
  logic [CW-1:0]               len_c, len_sat, tot, lsh;
  logic [WBITS+CODE_VAL_W-1:0] val_ext;
  logic [WBITS-1:0]            val_w, mask_w, acc_w, aln_w;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Merge pending bits with the new code and left-align the valid bits
  always_comb begin
    len_c   = CW'(in_data.code_length);
    len_sat = (len_c > CW'(MAX_CODE_BITS)) ? CW'(MAX_CODE_BITS) : len_c;
    tot     = len_sat + CW'(pend_cnt_r);
    val_ext = {{WBITS{1'b0}}, in_data.code_value};
    val_w   = val_ext[WBITS-1:0];
    mask_w  = ~({WBITS{1'b1}} << len_sat);
    acc_w   = (WBITS'(pend_bits_r) << len_sat) | (val_w & mask_w);
    // stale pending bits above the count fall off the top here
    lsh     = CW'(WBITS) - tot;
    aln_w   = acc_w << lsh;
    for (int k = 0; k < MAX_BYTES; k++) begin
      push_bytes[k] = aln_w[WBITS-1-BYTE_BITS*k -: BYTE_BITS];
    end
    push_nb       = NBW'(tot >> BSH);
    pend_bits_nxt = acc_w[PEND_W-1:0];
    pend_cnt_nxt  = tot[CNT_W-1:0];
  end

  // Only items that complete at least one byte go to the queue
  assign push = accept && (push_nb != '0);

  // Leftover bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (accept) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

>>> rtl/jbp_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on jbp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jbp_queue #(
  parameter int MAX_BYTES = 2,
  parameter int NBW       = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [MAX_BYTES-1:0][7:0] push_bytes,
  input  logic [NBW-1:0]            push_nb,
  output logic                      full,
  input  logic                      pop,
  output logic                      head_valid,
  output logic [MAX_BYTES-1:0][7:0] head_bytes,
  output logic [NBW-1:0]            head_nb
);
  import jbp_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  logic [MAX_BYTES-1:0][7:0] bytes_r [2];
  logic [NBW-1:0]            nb_r [2];
  logic                      wr_ptr_r, wr_ptr_nxt;
  logic                      rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                cnt_r, cnt_nxt;

  assign full       = (cnt_r == DEPTH);
  assign head_valid = (cnt_r != 2'd0);
  assign head_bytes = bytes_r[rd_ptr_r];
  assign head_nb    = nb_r[rd_ptr_r];

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      bytes_r[wr_ptr_r] <= push_bytes;
      nb_r[wr_ptr_r]    <= push_nb;
    end
  end

  `JBP_ASSERT(a_no_push_full, !(push && full), "descriptor pushed into full queue")
  `JBP_ASSERT(a_no_pop_empty, !(pop && !head_valid), "descriptor popped from empty queue")

endmodule

>>> rtl/jbp_back.sv
// Back end: walks the bytes of the head descriptor, inserts the stuffing
// zero after each 0xFF and drives the output register. Depends on jbp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jbp_back #(
  parameter int MAX_BYTES = 2,
  parameter int NBW       = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  logic [MAX_BYTES-1:0][7:0] head_bytes,
  input  logic [NBW-1:0]            head_nb,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output jbp_pkg::jbp_out_t         out_data
);
  import jbp_pkg::*;

  localparam int IW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 stuff_r, stuff_nxt;
  logic                 out_valid_r, out_valid_nxt;
  jbp_out_t             out_data_r, out_data_nxt;
  logic                 load, finish, is_last;
  logic [BYTE_BITS-1:0] cur_byte;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One byte per cycle into the output register while a descriptor is waiting and the output is not stalled
  always_comb begin
    cur_byte      = head_bytes[idx_r];
    is_last       = ((NBW'(idx_r) + NBW'(1)) == head_nb);
    load          = head_valid && (!out_valid_r || !out_stall);
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    stuff_nxt     = stuff_r;
    pop           = 1'b0;
    finish        = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (stuff_r) begin
        out_data_nxt.out_byte = STUFF_FILL;
        stuff_nxt             = 1'b0;
        finish                = 1'b1;
      end else begin
        out_data_nxt.out_byte = cur_byte;
        if (cur_byte == STUFF_MARK) begin
          stuff_nxt = 1'b1;
        end else begin
          finish = 1'b1;
        end
      end
      out_data_nxt.last_of_run = finish && is_last;
      // byte fully sent: advance or retire the descriptor
      if (finish) begin
        if (is_last) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      stuff_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      stuff_r     <= stuff_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `JBP_ASSERT(a_ff_not_last, (out_valid_r && out_data_r.out_byte == STUFF_MARK) |-> !out_data_r.last_of_run, "0xFF marked as last byte")
  `JBP_ASSERT_NEXT(a_ff_then_fill, out_valid_r && !out_stall && out_data_r.out_byte == STUFF_MARK, out_valid_r && out_data_r.out_byte == STUFF_FILL, "0xFF not followed by stuffing zero")

endmodule

>>> rtl/jpeg_bit_packer_byte_stuffing_core.sv
// Entropy bit packer with 0xFF/0x00 stuffing. A code can be taken every cycle;
// the bytes that it completes pass through the descriptor queue, then the output
// register. The back end sends one byte per cycle while out_stall is low, and an
// item yields 0 to 4 output bytes at 16-bit codes; the input stalls while both
// queue entries are waiting.
// Synchronous active-low reset clears pending bits, the queue and out_valid.
module jpeg_bit_packer_byte_stuffing_core #(
  parameter int MAX_CODE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jbp_pkg::jbp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jbp_pkg::jbp_out_t out_data
);
  import jbp_pkg::*;

  localparam int MAX_BYTES = (MAX_CODE_BITS + PEND_W) / BYTE_BITS;
  localparam int NBW       = $clog2(MAX_BYTES + 1);

  logic                      push, q_full, pop, head_valid;
  logic [MAX_BYTES-1:0][7:0] push_bytes, head_bytes;
  logic [NBW-1:0]            push_nb, head_nb;

  // Accept and split codes into bytes
  jbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .MAX_BYTES     (MAX_BYTES),
    .NBW           (NBW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_bytes (push_bytes),
    .push_nb    (push_nb)
  );

  // Decoupling queue
  jbp_queue #(
    .MAX_BYTES (MAX_BYTES),
    .NBW       (NBW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_bytes (push_bytes),
    .push_nb    (push_nb),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_bytes (head_bytes),
    .head_nb    (head_nb)
  );

  // Byte output with stuffing
  jbp_back #(
    .MAX_BYTES (MAX_BYTES),
    .NBW       (NBW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_bytes (head_bytes),
    .head_nb    (head_nb),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
